// File: src/hbfp_pkg.sv
// ----------------------------------------------------------------------------
// hbfp_pkg
// Shared types and constants for the header block field parser: item
// structs, event codes, queue sizing and the static table range check.
// ----------------------------------------------------------------------------
`default_nettype none

package hbfp_pkg;

  // static table size; valid indexes are 1..STATIC_TABLE_ENTRIES
  localparam int STATIC_TABLE_ENTRIES = 61;

  localparam int IDX_W  = 7;
  localparam int BYTE_W = 8;

  localparam logic [IDX_W-1:0] TABLE_LAST = IDX_W'(STATIC_TABLE_ENTRIES);

  // byte patterns of the representation prefixes
  localparam logic [BYTE_W-1:0] TOP_BIT_MASK  = 8'h80;
  localparam logic [BYTE_W-1:0] PREFIX_MASK   = 8'hc0;
  localparam logic [BYTE_W-1:0] LIT_PREFIX    = 8'h40;
  localparam logic [BYTE_W-1:0] LOW7_MASK     = 8'h7f;
  localparam logic [BYTE_W-1:0] LOW6_MASK     = 8'h3f;

  // decoupling queue between classifier and phase machine
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // event codes
  typedef enum logic [2:0] {
    EV_CONSUMED    = 3'd0,
    EV_INDEXED     = 3'd1,
    EV_NEW_NAME    = 3'd2,
    EV_NAME_BYTE   = 3'd3,
    EV_VALUE_BYTE  = 3'd4,
    EV_IDX_NAME    = 3'd5,
    EV_UNSUPPORTED = 3'd6
  } ev_kind_t;

  // input word
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              block_end;
  } in_item_t;

  // result word
  typedef struct packed {
    ev_kind_t          event_kind;
    logic [IDX_W-1:0]  field_index;
    logic              in_static_table;
    logic [BYTE_W-1:0] data_byte;
    logic              huffman_flag;
    logic              end_of_block;
    logic              truncated;
  } out_item_t;

  // classified byte, as held in the queue
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              top_bit;
    logic              new_name;
    logic              idx_name;
    logic              low7_ones;
    logic              low6_ones;
    logic              low7_zero;
    logic              idx7_hit;
    logic              idx6_hit;
  } cls_t;

  // queue status seen by the back end and the top level
  typedef struct packed {
    logic              not_empty;
    logic              full;
    logic [QCNT_W-1:0] level;
  } q_stat_t;

  // index lies in the static table
  function automatic logic in_table(input logic [IDX_W-1:0] idx);
    in_table = (idx != '0) && (idx <= TABLE_LAST);
  endfunction

endpackage

`default_nettype wire

// File: src/hbfp_front.sv
// ----------------------------------------------------------------------------
// hbfp_front
// Byte classifier: decodes prefix patterns, all-ones integers, zero
// lengths and static table hits for one incoming word.
// ----------------------------------------------------------------------------
`default_nettype none

module hbfp_front
  import hbfp_pkg::*;
(
  input  in_item_t item_i,
  output cls_t     cls_o
);

  logic [BYTE_W-1:0] b;

  assign b = item_i.in_byte;

  // prefix and integer decode
  always_comb begin
    cls_o.data      = b;
    cls_o.last      = item_i.block_end;
    cls_o.top_bit   = (b & TOP_BIT_MASK) != '0;
    cls_o.new_name  = (b == LIT_PREFIX);
    cls_o.idx_name  = ((b & PREFIX_MASK) == LIT_PREFIX) && (b != LIT_PREFIX);
    cls_o.low7_ones = (b & LOW7_MASK) == LOW7_MASK;
    cls_o.low6_ones = (b & LOW6_MASK) == LOW6_MASK;
    cls_o.low7_zero = (b & LOW7_MASK) == '0;
    cls_o.idx7_hit  = in_table(b[IDX_W-1:0]);
    cls_o.idx6_hit  = in_table({1'b0, b[IDX_W-2:0]});
  end

endmodule

`default_nettype wire

// File: src/hbfp_queue.sv
// ----------------------------------------------------------------------------
// hbfp_queue
// Short FIFO of classified bytes between classifier and phase machine.
// ----------------------------------------------------------------------------
`default_nettype none

module hbfp_queue
  import hbfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cls_t    push_item,
  input  logic    pop,
  output cls_t    head,
  output q_stat_t stat
);

  cls_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign do_push = push && (count_r != QCNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      // both or neither: level unchanged
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head           = mem_r[rd_ptr_r];
  assign stat.not_empty = (count_r != '0);
  assign stat.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.level     = count_r;

endmodule

`default_nettype wire

// File: src/hbfp_back.sv
// ----------------------------------------------------------------------------
// hbfp_back
// Parse phase machine: walks literal lengths and string bytes, builds one
// result word per byte and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbfp_back
  import hbfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cls_t      head,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_NAME_LEN   = 3'd1,
    PH_NAME_BYTES = 3'd2,
    PH_VAL_LEN    = 3'd3,
    PH_VAL_BYTES  = 3'd4
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] bytes_left_r, bytes_left_nxt;
  logic             emit_value_r, emit_value_nxt;
  logic             huf_r, huf_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r, res;
  logic [IDX_W-1:0] dec_left;

  // take the head word when the output register is free or draining
  assign pop      = q_stat.not_empty && (!out_valid_r || !out_stall);
  assign dec_left = bytes_left_r - 1'b1;

  // phase update and result build
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    emit_value_nxt = emit_value_r;
    huf_nxt        = huf_r;
    res            = '0;
    res.event_kind = EV_CONSUMED;

    unique case (phase_r)
      PH_NAME_LEN, PH_VAL_LEN: begin
        // string length byte
        huf_nxt          = head.top_bit;
        res.huffman_flag = head.top_bit;
        priority if (head.low7_ones) begin
          res.event_kind = EV_UNSUPPORTED;
          phase_nxt      = PH_IDLE;
          bytes_left_nxt = '0;
        end else if (head.low7_zero) begin
          phase_nxt = (phase_r == PH_NAME_LEN) ? PH_VAL_LEN : PH_IDLE;
        end else begin
          bytes_left_nxt = head.data[IDX_W-1:0];
          phase_nxt      = (phase_r == PH_NAME_LEN) ? PH_NAME_BYTES : PH_VAL_BYTES;
        end
      end
      PH_NAME_BYTES: begin
        res.event_kind   = EV_NAME_BYTE;
        res.data_byte    = head.data;
        res.huffman_flag = huf_r;
        bytes_left_nxt   = dec_left;
        if (dec_left == '0) begin
          phase_nxt = PH_VAL_LEN;
        end
      end
      PH_VAL_BYTES: begin
        if (emit_value_r) begin
          res.event_kind = EV_VALUE_BYTE;
          res.data_byte  = head.data;
        end
        res.huffman_flag = huf_r;
        bytes_left_nxt   = dec_left;
        if (dec_left == '0) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        // idle: representation prefix
        phase_nxt = PH_IDLE;
        priority if (head.top_bit) begin
          if (head.low7_ones) begin
            res.event_kind = EV_UNSUPPORTED;
          end else begin
            res.event_kind      = EV_INDEXED;
            res.field_index     = head.data[IDX_W-1:0];
            res.in_static_table = head.idx7_hit;
          end
        end else if (head.new_name) begin
          res.event_kind = EV_NEW_NAME;
          emit_value_nxt = 1'b1;
          phase_nxt      = PH_NAME_LEN;
        end else if (head.idx_name) begin
          if (head.low6_ones) begin
            res.event_kind = EV_UNSUPPORTED;
          end else begin
            res.event_kind      = EV_IDX_NAME;
            res.field_index     = {1'b0, head.data[IDX_W-2:0]};
            res.in_static_table = head.idx6_hit;
            emit_value_nxt      = 1'b0;
            phase_nxt           = PH_VAL_LEN;
          end
        end else begin
          // any other byte is consumed silently
          res.event_kind = EV_CONSUMED;
        end
      end
    endcase

    // block end closes the block and flags an open field
    res.end_of_block = head.last;
    if (head.last) begin
      res.truncated  = (phase_nxt != PH_IDLE);
      phase_nxt      = PH_IDLE;
      bytes_left_nxt = '0;
      emit_value_nxt = 1'b0;
      huf_nxt        = 1'b0;
    end
  end

  // parse state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bytes_left_r <= '0;
      emit_value_r <= 1'b0;
      huf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        phase_r      <= phase_nxt;
        bytes_left_r <= bytes_left_nxt;
        emit_value_r <= emit_value_nxt;
        huf_r        <= huf_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: src/header_block_field_parser.sv
// ----------------------------------------------------------------------------
// header_block_field_parser
// Header block byte parser: one event word per header byte, with a byte
// classifier, a four-entry queue and a phase machine behind it.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   in      | input     | in_valid/in_stall  | in_item   (in_item_t)
//   out     | output    | out_valid/out_stall| out_item  (out_item_t)
//
// One byte is accepted per cycle while in_stall is low. Each accepted byte
// is written into the queue, and the phase machine pops it from there and
// loads its result into the output register. It retires one queued byte per
// cycle unless out_stall holds the output register, so sustained rate is one
// word per cycle; in_stall rises only when the four-entry queue is full.
// Synchronous active-low reset returns the parser to idle and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module header_block_field_parser
  import hbfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  cls_t    cls;
  cls_t    head;
  q_stat_t q_stat;
  logic    pop;

  // classify
  hbfp_front u_front (
    .item_i (in_item),
    .cls_o  (cls)
  );

  // decouple
  hbfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (cls),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  assign in_stall = q_stat.full;

  // parse
  hbfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  // queue never overfills
  a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue level above depth");

  // truncation only on the last word of a block
  a_trunc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.truncated |-> out_item.end_of_block)
    else $error("truncated without end of block");

  // an index is only reported for indexed events
  a_index_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.field_index != '0) |->
      (out_item.event_kind == EV_INDEXED) || (out_item.event_kind == EV_IDX_NAME))
    else $error("field index on non-indexed event");

  // a data byte is only carried by string byte events
  a_data_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.data_byte != '0) |->
      (out_item.event_kind == EV_NAME_BYTE) || (out_item.event_kind == EV_VALUE_BYTE))
    else $error("data byte on non-string event");

  // the phase machine only pops a non-empty queue
  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: tb/header_block_field_parser_tb.sv
// ----------------------------------------------------------------------------
// header_block_field_parser_tb
// Self-checking bench for the header block field parser. A short directed
// table covers the prefix extremes, every event kind, all-ones prefixes,
// zero lengths and block ends inside open fields. It is followed by about
// 750 random bytes, most of them built as well-formed representations with
// random content. Each accepted byte runs through a bench-side parser model
// that predicts the event word. Both sides of the DUT idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module header_block_field_parser_tb
  import hbfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 750;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_NAME_LEN   = 3'd1,
    PH_NAME_BYTES = 3'd2,
    PH_VAL_LEN    = 3'd3,
    PH_VAL_BYTES  = 3'd4
  } phase_t;

  typedef struct {
    in_item_t  w;
    bit        typed;
    out_item_t exp;
    bit        drain_first;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // bench-side parser state
  phase_t     pp_phase;
  logic [6:0] str_left;
  logic       show_value;
  logic       huff_bit;

  stim_row_t byte_plan[$];
  stim_row_t sent_q[$];
  out_item_t event_q[$];

  int        mismatches;
  int        idle_cycles;
  int        rx_gap;
  int        rx_count;
  int        plan_len;
  bit        block_cut;
  stim_row_t acc_row;
  out_item_t predicted;

  header_block_field_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_parser();
    pp_phase   = PH_IDLE;
    str_left   = '0;
    show_value = 1'b0;
    huff_bit   = 1'b0;
  endfunction

  function automatic logic in_static_range(input logic [6:0] idx);
    return (idx != 7'd0) && (int'(idx) <= STATIC_TABLE_ENTRIES);
  endfunction

  // string length byte; zero length jumps straight to zero_phase
  function automatic ev_kind_t take_len(input logic [7:0] b, input phase_t nxt,
                                        input phase_t zero_phase);
    huff_bit = b[7];
    if (b[6:0] == LOW7_MASK[6:0]) begin
      pp_phase = PH_IDLE;
      str_left = '0;
      return EV_UNSUPPORTED;
    end
    if (b[6:0] == 7'd0) begin
      pp_phase = zero_phase;
    end else begin
      str_left = b[6:0];
      pp_phase = nxt;
    end
    return EV_CONSUMED;
  endfunction

  function automatic out_item_t parse_byte(input in_item_t w);
    out_item_t  r;
    logic [7:0] b;
    r = '0;
    r.event_kind = EV_CONSUMED;
    b = w.in_byte;
    case (pp_phase)
      PH_NAME_LEN: begin
        r.event_kind   = take_len(b, PH_NAME_BYTES, PH_VAL_LEN);
        r.huffman_flag = huff_bit;
      end
      PH_NAME_BYTES: begin
        r.event_kind   = EV_NAME_BYTE;
        r.data_byte    = b;
        r.huffman_flag = huff_bit;
        str_left       = str_left - 7'd1;
        if (str_left == 7'd0) pp_phase = PH_VAL_LEN;
      end
      PH_VAL_LEN: begin
        r.event_kind   = take_len(b, PH_VAL_BYTES, PH_IDLE);
        r.huffman_flag = huff_bit;
      end
      PH_VAL_BYTES: begin
        if (show_value) begin
          r.event_kind = EV_VALUE_BYTE;
          r.data_byte  = b;
        end
        r.huffman_flag = huff_bit;
        str_left       = str_left - 7'd1;
        if (str_left == 7'd0) pp_phase = PH_IDLE;
      end
      default: begin
        pp_phase = PH_IDLE;
        if ((b & TOP_BIT_MASK) != 8'd0) begin
          if (b[6:0] == LOW7_MASK[6:0]) begin
            r.event_kind = EV_UNSUPPORTED;
          end else begin
            r.event_kind      = EV_INDEXED;
            r.field_index     = b[6:0];
            r.in_static_table = in_static_range(b[6:0]);
          end
        end else if (b == LIT_PREFIX) begin
          r.event_kind = EV_NEW_NAME;
          show_value   = 1'b1;
          pp_phase     = PH_NAME_LEN;
        end else if ((b & PREFIX_MASK) == LIT_PREFIX) begin
          if (b[5:0] == LOW6_MASK[5:0]) begin
            r.event_kind = EV_UNSUPPORTED;
          end else begin
            r.event_kind      = EV_IDX_NAME;
            r.field_index     = {1'b0, b[5:0]};
            r.in_static_table = in_static_range({1'b0, b[5:0]});
            show_value        = 1'b0;
            pp_phase          = PH_VAL_LEN;
          end
        end
      end
    endcase
    // block end closes whatever is open
    r.end_of_block = w.block_end;
    if (w.block_end) begin
      r.truncated = (pp_phase != PH_IDLE);
      clear_parser();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic out_item_t mk(input ev_kind_t kind, input int idx, input logic stat,
                                   input int data, input logic huf, input logic eob,
                                   input logic trunc);
    out_item_t r;
    r.event_kind      = kind;
    r.field_index     = 7'(idx);
    r.in_static_table = stat;
    r.data_byte       = 8'(data);
    r.huffman_flag    = huf;
    r.end_of_block    = eob;
    r.truncated       = trunc;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [7:0] b, input logic last, input bit typed,
                                    input out_item_t exp);
    stim_row_t r;
    r.w.in_byte   = b;
    r.w.block_end = last;
    r.typed       = typed;
    r.exp         = exp;
    r.drain_first = 1'b0;
    return r;
  endfunction

  // random byte with an occasional block end
  task automatic plan_byte(input logic [7:0] b);
    logic last;
    last = ($urandom_range(0, 39) == 0);
    byte_plan.push_back(row(b, last, 1'b0, '0));
    if (last) block_cut = 1'b1;
  endtask

  // length byte plus string bytes; mostly short, sometimes long or all-ones
  task automatic plan_string();
    int sel;
    int len;
    sel = $urandom_range(0, 99);
    if (sel < 5) len = 127;
    else if (sel < 10) len = $urandom_range(60, 126);
    else if (sel < 20) len = 0;
    else len = $urandom_range(1, 6);
    plan_byte({1'($urandom), 7'(len)});
    if (len == 127) return;
    for (int i = 0; i < len; i++) begin
      if (block_cut) return;
      plan_byte(8'($urandom));
    end
  endtask

  task automatic plan_random();
    int sel;
    int start;
    start = byte_plan.size();
    while (byte_plan.size() - start < RANDOM_BYTES) begin
      block_cut = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        plan_byte({1'b1, 7'($urandom)});
      end else if (sel < 60) begin
        plan_byte(LIT_PREFIX);
        if (!block_cut) plan_string();
        if (!block_cut) plan_string();
      end else if (sel < 88) begin
        plan_byte({2'b01, 6'($urandom)});
        if (!block_cut) plan_string();
      end else begin
        plan_byte(8'($urandom));
      end
    end
    // hold off at the start and halfway until everything outstanding has drained
    byte_plan[start].drain_first = 1'b1;
    byte_plan[start + RANDOM_BYTES / 2].drain_first = 1'b1;
  endtask

  task automatic send_word(input stim_row_t r, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent_q.push_back(r);
    in_valid <= 1'b1;
    in_item  <= r.w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_word(input out_item_t e, input out_item_t a);
    if (a.event_kind !== e.event_kind) begin
      $error("event_kind: expected %0d, got %0d", e.event_kind, a.event_kind);
      mismatches++;
    end
    if (a.field_index !== e.field_index) begin
      $error("field_index: expected %0d, got %0d", e.field_index, a.field_index);
      mismatches++;
    end
    if (a.in_static_table !== e.in_static_table) begin
      $error("in_static_table: expected %0d, got %0d", e.in_static_table, a.in_static_table);
      mismatches++;
    end
    if (a.data_byte !== e.data_byte) begin
      $error("data_byte: expected %0h, got %0h", e.data_byte, a.data_byte);
      mismatches++;
    end
    if (a.huffman_flag !== e.huffman_flag) begin
      $error("huffman_flag: expected %0d, got %0d", e.huffman_flag, a.huffman_flag);
      mismatches++;
    end
    if (a.end_of_block !== e.end_of_block) begin
      $error("end_of_block: expected %0d, got %0d", e.end_of_block, a.end_of_block);
      mismatches++;
    end
    if (a.truncated !== e.truncated) begin
      $error("truncated: expected %0d, got %0d", e.truncated, a.truncated);
      mismatches++;
    end
  endtask

  // predict on each accepted byte, compare on each accepted event word
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        acc_row   = sent_q.pop_front();
        predicted = parse_byte(acc_row.w);
        event_q.push_back(acc_row.typed ? acc_row.exp : predicted);
      end
      if (out_valid && !out_stall) begin
        if (event_q.size() == 0) begin
          $error("unexpected event word: kind %0d", out_item.event_kind);
          mismatches++;
        end else begin
          check_word(event_q.pop_front(), out_item);
        end
      end
    end
  end

  // result side stall pattern
  initial begin
    rx_count = 0;
    @(posedge clk);
    forever begin
      rx_gap = (rx_count % 70 < 12) ? 0 : $urandom_range(0, 14);
      if (rx_gap > 0) begin
        out_stall <= 1'b1;
        repeat (rx_gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_count++;
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- main flow
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    out_stall  = 1'b0;
    mismatches = 0;
    clear_parser();

    // directed table: byte, block end, typed expectation
    byte_plan.push_back(row(8'h80, 1'b0, 1, mk(EV_INDEXED, 0, 0, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'h81, 1'b0, 1, mk(EV_INDEXED, 1, 1, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'hbd, 1'b0, 1, mk(EV_INDEXED, 61, 1, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'hbe, 1'b0, 1, mk(EV_INDEXED, 62, 0, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'hff, 1'b0, 1, mk(EV_UNSUPPORTED, 0, 0, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'h00, 1'b0, 1, mk(EV_CONSUMED, 0, 0, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'h7f, 1'b0, 1, mk(EV_UNSUPPORTED, 0, 0, 0, 0, 0, 0)));
    // indexed name, huffman value of two skipped bytes, block end on the last
    byte_plan.push_back(row(8'h41, 1'b0, 1, mk(EV_IDX_NAME, 1, 1, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'h82, 1'b0, 1, mk(EV_CONSUMED, 0, 0, 0, 1, 0, 0)));
    byte_plan.push_back(row(8'haa, 1'b0, 0, '0));
    byte_plan.push_back(row(8'h55, 1'b1, 0, '0));
    // new name, one name byte, all-ones value length
    byte_plan.push_back(row(8'h40, 1'b0, 1, mk(EV_NEW_NAME, 0, 0, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'h01, 1'b0, 0, '0));
    byte_plan.push_back(row(8'hff, 1'b0, 0, '0));
    byte_plan.push_back(row(8'hff, 1'b0, 0, '0));
    // new name, empty name, long value cut by block end
    byte_plan.push_back(row(8'h40, 1'b0, 1, mk(EV_NEW_NAME, 0, 0, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'h00, 1'b0, 0, '0));
    byte_plan.push_back(row(8'h7e, 1'b0, 0, '0));
    byte_plan.push_back(row(8'h00, 1'b1, 0, '0));
    // indexed name past the table, empty huffman value
    byte_plan.push_back(row(8'h7e, 1'b0, 1, mk(EV_IDX_NAME, 62, 0, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'h80, 1'b0, 0, '0));
    byte_plan.push_back(row(8'h3f, 1'b0, 1, mk(EV_CONSUMED, 0, 0, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'h40, 1'b1, 1, mk(EV_NEW_NAME, 0, 0, 0, 0, 1, 1)));
    byte_plan.push_back(row(8'hc0, 1'b0, 1, mk(EV_INDEXED, 64, 0, 0, 0, 0, 0)));
    byte_plan.push_back(row(8'hfe, 1'b1, 1, mk(EV_INDEXED, 126, 0, 0, 0, 1, 0)));
    plan_random();
    plan_len = byte_plan.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < plan_len; i++) begin
      if (byte_plan[i].drain_first) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (event_q.size() != 0) @(posedge clk);
      end
      send_word(byte_plan[i], (i % 90 < 16) ? 0 : $urandom_range(0, 14));
    end
    in_valid <= 1'b0;

    // let the pipeline drain and catch any stray word
    while (event_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/hbfp_pkg.sv
src/hbfp_front.sv
src/hbfp_queue.sv
src/hbfp_back.sv
src/header_block_field_parser.sv
tb/header_block_field_parser_tb.sv
